@@ src/rrp_pkg.sv @@
// Shared types, constants and helpers for the ring record placer.
package rrp_pkg;

  localparam int unsigned HEADER_BYTES  = 24;
  localparam int unsigned ALIGN_BYTES   = 8;
  localparam int unsigned ALIGN_LOG2    = $clog2(ALIGN_BYTES);
  localparam int unsigned LEN_IN_W      = 24;
  localparam int unsigned LEN_IN_MAX    = (1 << LEN_IN_W) - 1;
  localparam int unsigned RAW_W         =
      $clog2(HEADER_BYTES + 2 * LEN_IN_MAX + ALIGN_BYTES);
  localparam int unsigned RING_LOG2_W   = 5;
  localparam int unsigned RING_LOG2_MIN = 16;
  localparam int unsigned RING_LOG2_MAX = 30;
  localparam int unsigned RING_LOG2_RST = 16;
  localparam int unsigned SIZE_W        = RING_LOG2_MAX + 1;
  localparam int unsigned OFF_W         = RING_LOG2_MAX;
  localparam int unsigned TOT_W         = SIZE_W + 1;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned CFG_IDX_W     = 4;
  localparam int unsigned CFG_DATA_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_SIZE_LOG2 = 4'd0,
    CFG_WRAP_TYPE      = 4'd1
  } rrp_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_RECORD        = 3'd0,
    ST_WRAP_PAD      = 3'd1,
    ST_DROP_OVERSIZE = 3'd2,
    ST_DROP_BAD_RP   = 3'd3,
    ST_DROP_FULL     = 3'd4
  } rrp_status_e;

  typedef struct packed {
    logic [15:0]         rec_type;
    logic [15:0]         rec_flags;
    logic [LEN_IN_W-1:0] payload_len;
    logic [LEN_IN_W-1:0] data_len;
    logic [63:0]         read_pos;
    logic [62:0]         timestamp;
  } rrp_req_t;

  typedef struct packed {
    rrp_status_e       status;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] length;
    logic [15:0]       hdr_type;
    logic [15:0]       hdr_flags;
    logic [63:0]       sequence_res;
    logic [62:0]       stamp;
    logic [SIZE_W-1:0] zero_fill;
    logic [63:0]       write_pos;
    logic [63:0]       dropped_records;
    logic [63:0]       dropped_bytes;
    logic              last;
  } rrp_res_t;

  // Classified request as handed from front to back.
  typedef struct packed {
    logic [15:0]      rec_type;
    logic [15:0]      rec_flags;
    logic [63:0]      read_pos;
    logic [62:0]      timestamp;
    logic [RAW_W-1:0] raw;
    logic [RAW_W-1:0] rec;
    logic             oversize;
  } rrp_job_t;

  // Placement figures worked out against the current write position.
  typedef struct packed {
    rrp_job_t          job;
    logic              bad_rp;
    logic [SIZE_W-1:0] avail;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] rec_fin;
    logic [SIZE_W-1:0] pad;
    logic [TOT_W-1:0]  total;
  } rrp_eval_t;

  function automatic logic [SIZE_W-1:0] ring_size(input logic [RING_LOG2_W-1:0] lg);
    logic [RING_LOG2_W-1:0] c;
    c = lg;
    if (lg < RING_LOG2_W'(RING_LOG2_MIN)) c = RING_LOG2_W'(RING_LOG2_MIN);
    if (lg > RING_LOG2_W'(RING_LOG2_MAX)) c = RING_LOG2_W'(RING_LOG2_MAX);
    return SIZE_W'(1) << c;
  endfunction

endpackage

@@ src/ring_record_placer_core.sv @@
// Ring record placer: configuration registers, front end, request queue, back end.
// Path: a request passes through the request queue, the back end's evaluation register
// and its output register before its result is valid.
// Flow: the back end takes no new request until it has decided the last one; it first
// measures a request against the write position, then decides and updates it.
// Reset: asynchronous, clears ring state and counters; ring size log2 resets to 16.
module ring_record_placer_core #(
  parameter int unsigned QueueDepth = rrp_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rrp_pkg::rrp_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rrp_pkg::rrp_res_t             out_res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rrp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rrp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rrp_pkg::*;

  logic [RING_LOG2_W-1:0] ring_lg_q;
  logic [15:0]            wrap_type_q;
  logic [SIZE_W-1:0]      size;
  logic                   q_full, q_valid, push, pop;
  rrp_job_t               job_in, job_out;

  assign cfg_ready_o = 1'b1;
  assign size        = ring_size(ring_lg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_lg_q   <= RING_LOG2_W'(RING_LOG2_RST);
      wrap_type_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RING_SIZE_LOG2: ring_lg_q   <= cfg_data_i[RING_LOG2_W-1:0];
        CFG_WRAP_TYPE:      wrap_type_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  rrp_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .size_i     (size),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  rrp_queue #(
    .Depth (QueueDepth),
    .Width ($bits(rrp_job_t))
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (job_out)
  );

  rrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .size_i      (size),
    .wrap_type_i (wrap_type_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

@@ src/rrp_front.sv @@
// Front end: accepts requests, sizes and aligns the record, flags oversize.
module rrp_front (
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  rrp_pkg::rrp_req_t        in_req_i,
  input  logic [rrp_pkg::SIZE_W-1:0] size_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output rrp_pkg::rrp_job_t        job_o
);
  import rrp_pkg::*;

  logic [RAW_W-1:0] raw;
  logic [RAW_W-1:0] rec;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    raw = RAW_W'(HEADER_BYTES) + RAW_W'(in_req_i.payload_len) + RAW_W'(in_req_i.data_len);
    rec = ((raw + RAW_W'(ALIGN_BYTES - 1)) >> ALIGN_LOG2) << ALIGN_LOG2;
    job_o.rec_type  = in_req_i.rec_type;
    job_o.rec_flags = in_req_i.rec_flags;
    job_o.read_pos  = in_req_i.read_pos;
    job_o.timestamp = in_req_i.timestamp;
    job_o.raw       = raw;
    job_o.rec       = rec;
    job_o.oversize  = SIZE_W'(rec) > size_i;
  end

endmodule

@@ src/rrp_queue.sv @@
// Short request queue between the front and the back end.
module rrp_queue #(
  parameter int unsigned Depth = rrp_pkg::QUEUE_DEPTH,
  parameter int unsigned Width = $bits(rrp_pkg::rrp_job_t)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o
);
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

@@ src/rrp_back.sv @@
// Back end: checks space against the ring state, places records, emits headers.
module rrp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  rrp_pkg::rrp_job_t          job_i,
  output logic                       pop_o,
  input  logic [rrp_pkg::SIZE_W-1:0] size_i,
  input  logic [15:0]                wrap_type_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rrp_pkg::rrp_res_t          out_res_o
);
  import rrp_pkg::*;

  logic [63:0] wp_q, wp_d, seq_q, seq_d, drop_cnt_q, drop_cnt_d, drop_bytes_q, drop_bytes_d;
  rrp_eval_t   ev_q, ev_d;
  logic        ev_valid_q, ev_valid_d;
  rrp_res_t    out_q, out_d, pend_q, pend_d;
  logic        out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;

  logic              eval_load, decide, out_free;
  logic [64:0]       diff;
  logic [SIZE_W-1:0] mask, contig, tail, rec_ext;
  logic [OFF_W-1:0]  off;
  logic              fits, absorb;

  logic              full, dropped, wrap;
  rrp_status_e       drop_status;
  logic [SIZE_W-1:0] drop_len, rec_orig;
  rrp_res_t          drop_res, pad_res, rec_res;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign eval_load = job_valid_i && !ev_valid_q;
  assign decide    = ev_valid_q && !pend_valid_q && out_free;
  assign pop_o     = eval_load;

  // First half: measure the head request against the current write position.
  always_comb begin
    diff    = {1'b0, wp_q} - {1'b0, job_i.read_pos};
    mask    = size_i - SIZE_W'(1);
    off     = wp_q[OFF_W-1:0] & mask[OFF_W-1:0];
    contig  = size_i - SIZE_W'(off);
    rec_ext = SIZE_W'(job_i.rec);
    fits    = rec_ext <= contig;
    tail    = contig - rec_ext;
    absorb  = fits && (tail != '0) && (tail < SIZE_W'(HEADER_BYTES));

    ev_d.job     = job_i;
    ev_d.bad_rp  = diff[64] || (|diff[63:SIZE_W]) || (diff[SIZE_W-1:0] > size_i);
    ev_d.avail   = size_i - diff[SIZE_W-1:0];
    ev_d.off     = off;
    ev_d.rec_fin = absorb ? contig : rec_ext;
    ev_d.pad     = fits ? '0 : contig;
    ev_d.total   = TOT_W'(fits ? '0 : contig) + TOT_W'(absorb ? contig : rec_ext);
  end

  // Second half: decide drop or placement and build the results.
  always_comb begin
    full     = TOT_W'(ev_q.avail) < ev_q.total;
    dropped  = ev_q.job.oversize || ev_q.bad_rp || full;
    wrap     = ev_q.pad != '0;
    rec_orig = SIZE_W'(ev_q.job.rec);

    if (ev_q.job.oversize) begin
      drop_status = ST_DROP_OVERSIZE;
      drop_len    = rec_orig;
    end else if (ev_q.bad_rp) begin
      drop_status = ST_DROP_BAD_RP;
      drop_len    = rec_orig;
    end else begin
      drop_status = ST_DROP_FULL;
      drop_len    = ev_q.total[SIZE_W-1:0];
    end

    drop_res                 = '0;
    drop_res.status          = drop_status;
    drop_res.length          = drop_len;
    drop_res.write_pos       = wp_q;
    drop_res.dropped_records = drop_cnt_q + 64'd1;
    drop_res.dropped_bytes   = drop_bytes_q + 64'(drop_len);
    drop_res.last            = 1'b1;

    pad_res.status          = ST_WRAP_PAD;
    pad_res.offset          = ev_q.off;
    pad_res.length          = ev_q.pad;
    pad_res.hdr_type        = wrap_type_i;
    pad_res.hdr_flags       = '0;
    pad_res.sequence_res    = seq_q + 64'd1;
    pad_res.stamp           = ev_q.job.timestamp;
    pad_res.zero_fill       = '0;
    pad_res.write_pos       = wp_q + 64'(ev_q.pad);
    pad_res.dropped_records = drop_cnt_q;
    pad_res.dropped_bytes   = drop_bytes_q;
    pad_res.last            = 1'b0;

    rec_res.status          = ST_RECORD;
    rec_res.offset          = wrap ? '0 : ev_q.off;
    rec_res.length          = ev_q.rec_fin;
    rec_res.hdr_type        = ev_q.job.rec_type;
    rec_res.hdr_flags       = ev_q.job.rec_flags;
    rec_res.sequence_res    = seq_q + (wrap ? 64'd2 : 64'd1);
    rec_res.stamp           = ev_q.job.timestamp;
    rec_res.zero_fill       = ev_q.rec_fin - SIZE_W'(ev_q.job.raw);
    rec_res.write_pos       = wp_q + 64'(ev_q.total);
    rec_res.dropped_records = drop_cnt_q;
    rec_res.dropped_bytes   = drop_bytes_q;
    rec_res.last            = 1'b1;
  end

  always_comb begin
    wp_d         = wp_q;
    seq_d        = seq_q;
    drop_cnt_d   = drop_cnt_q;
    drop_bytes_d = drop_bytes_q;
    ev_valid_d   = ev_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    if (eval_load) ev_valid_d = 1'b1;

    if (decide) begin
      ev_valid_d  = 1'b0;
      out_valid_d = 1'b1;
      if (dropped) begin
        out_d        = drop_res;
        drop_cnt_d   = drop_res.dropped_records;
        drop_bytes_d = drop_res.dropped_bytes;
      end else begin
        wp_d  = rec_res.write_pos;
        seq_d = rec_res.sequence_res;
        if (wrap) begin
          // Pad goes first, hold the record header behind it.
          out_d        = pad_res;
          pend_d       = rec_res;
          pend_valid_d = 1'b1;
        end else begin
          out_d = rec_res;
        end
      end
    end else if (pend_valid_q && out_free) begin
      out_d        = pend_q;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      seq_q        <= '0;
      drop_cnt_q   <= '0;
      drop_bytes_q <= '0;
      ev_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      wp_q         <= wp_d;
      seq_q        <= seq_d;
      drop_cnt_q   <= drop_cnt_d;
      drop_bytes_q <= drop_bytes_d;
      ev_valid_q   <= ev_valid_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_load) ev_q <= ev_d;
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule
